@@ sv/tdq_pkg.sv @@
// Shared types and constants for the timer deadline queue.
package tdq_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int TIME_W     = 32;
    localparam int MS_W       = 24;
    localparam int HANDLE_W   = 4;
    localparam int KIND_W     = 3;

    // At most this many slots fire on one tick
    localparam int MAX_FIRE   = 16;
    localparam int FIRE_IDX_W = 4;
    localparam int FIRE_CNT_W = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD_ONESHOT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_PERIODIC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP         = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK         = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ADDED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOPPED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIRED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd4;

    // Where a single result takes its handle from
    typedef enum logic [1:0] {
        HS_ZERO,
        HS_SCAN,
        HS_TARGET
    } t_hsel;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              scan_start;
        logic              scan_stop;
        logic              addr_target;
        logic              buf_clear;
        logic              sort_en;
        logic              min_clear;
        logic              min_en;
        logic              wr_add;
        logic              wr_stop;
        logic              wr_apply;
        logic              bi_clear;
        logic              bi_inc;
        logic              res_set;
        logic [KIND_W-1:0] res_kind;
        t_hsel             res_hsel;
        logic              out_load;
    } t_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic found_free;
        logic scan_last;
        logic buf_empty;
        logic bi_last;
        logic out_free;
        logic out_last;
    } t_sts;

endpackage

@@ sv/tdq_datapath.sv @@
// Slot table, scan engine, fire sort buffer, minimum tracker and result register.
module tdq_datapath #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tdq_pkg::t_ctl                   i_ctl,
    output tdq_pkg::t_sts                   o_sts,
    input  logic [tdq_pkg::CMD_W-1:0]       i_command,
    input  logic [tdq_pkg::TIME_W-1:0]      i_current_time,
    input  logic [tdq_pkg::MS_W-1:0]        i_offset_ms,
    input  logic [tdq_pkg::MS_W-1:0]        i_period_ms,
    input  logic [tdq_pkg::HANDLE_W-1:0]    i_target_handle,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [tdq_pkg::KIND_W-1:0]      o_kind,
    output logic [tdq_pkg::HANDLE_W-1:0]    o_handle,
    output logic [tdq_pkg::TIME_W-1:0]      o_next_deadline,
    output logic                            o_next_valid,
    output logic                            o_last
);
    import tdq_pkg::*;

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);
    localparam logic [AW+HANDLE_W-1:0] SLOT_LIMIT = (AW+HANDLE_W)'(SLOT_COUNT);

    // Captured request
    logic [CMD_W-1:0]    r_cmd;
    logic [TIME_W-1:0]   r_now;
    logic [MS_W-1:0]     r_ofs;
    logic [MS_W-1:0]     r_per;
    logic [HANDLE_W-1:0] r_tgt;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_command;
            r_now <= i_current_time;
            r_ofs <= i_offset_ms;
            r_per <= i_period_ms;
            r_tgt <= i_target_handle;
        end
    end

    // Slot storage: used bits in flops, the rest in memories
    logic [SLOT_COUNT-1:0] r_used;
    logic [TIME_W-1:0]     r_mem_deadline [SLOT_COUNT];
    logic [MS_W-1:0]       r_mem_period   [SLOT_COUNT];
    logic                  r_mem_periodic [SLOT_COUNT];
    logic                  r_mem_stopped  [SLOT_COUNT];

    // Scan engine: one slot address per cycle, registered read
    logic [AW-1:0]     r_addr;
    logic              r_issue;
    logic              r_pv;
    logic [AW-1:0]     r_rd_addr;
    logic              r_rd_used;
    logic [TIME_W-1:0] r_rd_deadline;
    logic [MS_W-1:0]   r_rd_period;
    logic              r_rd_periodic;
    logic              r_rd_stopped;

    logic [AW+HANDLE_W-1:0] tgt_ext;
    logic [AW-1:0]          tgt_addr;
    logic                   tgt_ok;

    assign tgt_ext  = {{AW{1'b0}}, i_target_handle};
    assign tgt_addr = tgt_ext[AW-1:0];
    assign tgt_ok   = ({{AW{1'b0}}, r_tgt} < SLOT_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_issue <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            priority if (i_ctl.scan_start) begin
                r_addr  <= '0;
                r_issue <= 1'b1;
                r_pv    <= 1'b0;
            end else if (i_ctl.scan_stop) begin
                r_issue <= 1'b0;
                r_pv    <= 1'b0;
            end else if (i_ctl.addr_target) begin
                r_addr  <= tgt_addr;
                r_issue <= 1'b0;
                r_pv    <= 1'b0;
            end else begin
                r_pv <= r_issue;
                if (r_issue) begin
                    if (r_addr != LAST_SLOT) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    r_issue <= (r_addr != LAST_SLOT);
                end
            end
        end
    end

    // Fire buffer: expired slots kept sorted by deadline, then slot
    logic [TIME_W-1:0]     r_buf_dl    [MAX_FIRE];
    logic [AW-1:0]         r_buf_h     [MAX_FIRE];
    logic                  r_buf_rearm [MAX_FIRE];
    logic [MS_W-1:0]       r_buf_per   [MAX_FIRE];
    logic [FIRE_CNT_W-1:0] r_cnt;
    logic [FIRE_IDX_W-1:0] r_bi;

    logic [TIME_W-1:0] n_buf_dl    [MAX_FIRE];
    logic [AW-1:0]     n_buf_h     [MAX_FIRE];
    logic              n_buf_rearm [MAX_FIRE];
    logic [MS_W-1:0]   n_buf_per   [MAX_FIRE];
    logic [MAX_FIRE-1:0] keep;
    logic              ins_en;
    logic              new_rearm;

    assign ins_en    = i_ctl.sort_en && r_pv && r_rd_used && (r_rd_deadline <= r_now);
    assign new_rearm = r_rd_periodic && !r_rd_stopped;

    // Each entry keeps, takes the new one, or shifts down from its neighbour
    always_comb begin
        for (int j = 0; j < MAX_FIRE; j++) begin
            keep[j] = (FIRE_CNT_W'(j) < r_cnt) && !(r_buf_dl[j] > r_rd_deadline);
        end
        for (int j = 0; j < MAX_FIRE; j++) begin
            if (keep[j]) begin
                n_buf_dl[j]    = r_buf_dl[j];
                n_buf_h[j]     = r_buf_h[j];
                n_buf_rearm[j] = r_buf_rearm[j];
                n_buf_per[j]   = r_buf_per[j];
            end else if (j == 0 || keep[(j == 0) ? 0 : j-1]) begin
                n_buf_dl[j]    = r_rd_deadline;
                n_buf_h[j]     = r_rd_addr;
                n_buf_rearm[j] = new_rearm;
                n_buf_per[j]   = r_rd_period;
            end else begin
                n_buf_dl[j]    = r_buf_dl[(j == 0) ? 0 : j-1];
                n_buf_h[j]     = r_buf_h[(j == 0) ? 0 : j-1];
                n_buf_rearm[j] = r_buf_rearm[(j == 0) ? 0 : j-1];
                n_buf_per[j]   = r_buf_per[(j == 0) ? 0 : j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ins_en) begin
            r_buf_dl    <= n_buf_dl;
            r_buf_h     <= n_buf_h;
            r_buf_rearm <= n_buf_rearm;
            r_buf_per   <= n_buf_per;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_bi  <= '0;
        end else begin
            if (i_ctl.buf_clear) begin
                r_cnt <= '0;
            end else if (ins_en && r_cnt != FIRE_CNT_W'(MAX_FIRE)) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_ctl.bi_clear) begin
                r_bi <= '0;
            end else if (i_ctl.bi_inc) begin
                r_bi <= r_bi + 1'b1;
            end
        end
    end

    // Buffer entry at the current index
    logic [AW-1:0]     cur_h;
    logic              cur_rearm;
    logic [MS_W-1:0]   cur_per;
    logic              bi_last;

    assign cur_h     = r_buf_h[r_bi];
    assign cur_rearm = r_buf_rearm[r_bi];
    assign cur_per   = r_buf_per[r_bi];
    assign bi_last   = ({1'b0, r_bi} == (r_cnt - 1'b1));

    // Table write port
    logic [AW-1:0]     wa;
    logic [TIME_W-1:0] wdl;
    logic              dl_we;
    logic              stop_we;

    assign wa      = i_ctl.wr_apply ? cur_h : r_rd_addr;
    assign wdl     = i_ctl.wr_apply ? (r_now + TIME_W'(cur_per)) : (r_now + TIME_W'(r_ofs));
    assign dl_we   = i_ctl.wr_add || (i_ctl.wr_apply && cur_rearm);
    assign stop_we = i_ctl.wr_add || (i_ctl.wr_stop && r_rd_used && tgt_ok);

    always_ff @(posedge i_clk) begin
        if (dl_we) begin
            r_mem_deadline[wa] <= wdl;
        end
        if (i_ctl.wr_add) begin
            r_mem_period[wa]   <= (r_cmd == CMD_ADD_PERIODIC) ? r_per : '0;
            r_mem_periodic[wa] <= (r_cmd == CMD_ADD_PERIODIC);
        end
        if (stop_we) begin
            r_mem_stopped[wa] <= i_ctl.wr_stop;
        end
        r_rd_addr     <= r_addr;
        r_rd_used     <= r_used[r_addr];
        r_rd_deadline <= r_mem_deadline[r_addr];
        r_rd_period   <= r_mem_period[r_addr];
        r_rd_periodic <= r_mem_periodic[r_addr];
        r_rd_stopped  <= r_mem_stopped[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_ctl.wr_add) begin
            r_used[wa] <= 1'b1;
        end else if (i_ctl.wr_apply && !cur_rearm) begin
            r_used[wa] <= 1'b0;
        end
    end

    // Earliest pending deadline
    logic [TIME_W-1:0] r_best;
    logic              r_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any  <= 1'b0;
            r_best <= '0;
        end else if (i_ctl.min_clear) begin
            r_any  <= 1'b0;
        end else if (i_ctl.min_en && r_pv && r_rd_used &&
                     (!r_any || r_rd_deadline < r_best)) begin
            r_any  <= 1'b1;
            r_best <= r_rd_deadline;
        end
    end

    // Single-result kind and handle
    logic [KIND_W-1:0]      r_res_kind;
    logic [HANDLE_W-1:0]    r_res_handle;
    logic [AW+HANDLE_W-1:0] scan_h_ext;
    logic [AW+HANDLE_W-1:0] buf_h_ext;

    assign scan_h_ext = {{HANDLE_W{1'b0}}, r_rd_addr};
    assign buf_h_ext  = {{HANDLE_W{1'b0}}, cur_h};

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_set) begin
            r_res_kind <= i_ctl.res_kind;
            unique case (i_ctl.res_hsel)
                HS_SCAN:   r_res_handle <= scan_h_ext[HANDLE_W-1:0];
                HS_TARGET: r_res_handle <= r_tgt;
                default:   r_res_handle <= '0;
            endcase
        end
    end

    // Result register
    logic use_buf;
    logic out_last;
    logic r_out_valid;

    assign use_buf  = (r_cmd == CMD_TICK) && (r_cnt != '0);
    assign out_last = !use_buf || bi_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_kind          <= use_buf ? KIND_FIRED : r_res_kind;
            o_handle        <= use_buf ? buf_h_ext[HANDLE_W-1:0] : r_res_handle;
            o_next_deadline <= r_any ? r_best : '0;
            o_next_valid    <= r_any;
            o_last          <= out_last;
        end
    end

    assign o_valid = r_out_valid;

    // Status back to the controller
    assign o_sts.found_free = r_pv && !r_rd_used;
    assign o_sts.scan_last  = r_pv && (r_rd_addr == LAST_SLOT);
    assign o_sts.buf_empty  = (r_cnt == '0);
    assign o_sts.bi_last    = bi_last;
    assign o_sts.out_free   = !r_out_valid || i_ready;
    assign o_sts.out_last   = out_last;

endmodule

@@ sv/tdq_ctrl.sv @@
// Sequencing state machine for the timer deadline queue.
module tdq_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [tdq_pkg::CMD_W-1:0] i_command,
    input  tdq_pkg::t_sts             i_sts,
    output logic                      o_ready,
    output tdq_pkg::t_ctl             o_ctl
);
    import tdq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_FREE      = 9'b000000010,
        S_STOP_RD   = 9'b000000100,
        S_STOP_WR   = 9'b000001000,
        S_FIRE      = 9'b000010000,
        S_APPLY     = 9'b000100000,
        S_MIN_START = 9'b001000000,
        S_MIN       = 9'b010000000,
        S_OUT       = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_ctl.load = 1'b1;
                    unique case (i_command)
                        CMD_STOP: begin
                            o_ctl.addr_target = 1'b1;
                            n_state = S_STOP_RD;
                        end
                        CMD_TICK: begin
                            o_ctl.scan_start = 1'b1;
                            o_ctl.buf_clear  = 1'b1;
                            n_state = S_FIRE;
                        end
                        default: begin
                            o_ctl.scan_start = 1'b1;
                            n_state = S_FREE;
                        end
                    endcase
                end
            end
            // Lowest free slot; the scan stops at the first free slot or after the last one
            S_FREE: begin
                if (i_sts.found_free) begin
                    o_ctl.scan_stop = 1'b1;
                    o_ctl.wr_add    = 1'b1;
                    o_ctl.res_set   = 1'b1;
                    o_ctl.res_kind  = KIND_ADDED;
                    o_ctl.res_hsel  = HS_SCAN;
                    n_state = S_MIN_START;
                end else if (i_sts.scan_last) begin
                    o_ctl.scan_stop = 1'b1;
                    o_ctl.res_set   = 1'b1;
                    o_ctl.res_kind  = KIND_FULL;
                    o_ctl.res_hsel  = HS_ZERO;
                    n_state = S_MIN_START;
                end
            end
            // Target slot is being read
            S_STOP_RD: begin
                n_state = S_STOP_WR;
            end
            S_STOP_WR: begin
                o_ctl.wr_stop  = 1'b1;
                o_ctl.res_set  = 1'b1;
                o_ctl.res_kind = KIND_STOPPED;
                o_ctl.res_hsel = HS_TARGET;
                n_state = S_MIN_START;
            end
            // Collect expired slots in firing order
            S_FIRE: begin
                o_ctl.sort_en = 1'b1;
                if (i_sts.scan_last) begin
                    o_ctl.bi_clear = 1'b1;
                    n_state = S_APPLY;
                end
            end
            // Re-arm or free each fired slot
            S_APPLY: begin
                if (i_sts.buf_empty) begin
                    o_ctl.res_set  = 1'b1;
                    o_ctl.res_kind = KIND_NONE;
                    o_ctl.res_hsel = HS_ZERO;
                    n_state = S_MIN_START;
                end else begin
                    o_ctl.wr_apply = 1'b1;
                    o_ctl.bi_inc   = 1'b1;
                    if (i_sts.bi_last) begin
                        n_state = S_MIN_START;
                    end
                end
            end
            S_MIN_START: begin
                o_ctl.scan_start = 1'b1;
                o_ctl.min_clear  = 1'b1;
                o_ctl.bi_clear   = 1'b1;
                n_state = S_MIN;
            end
            S_MIN: begin
                o_ctl.min_en = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_OUT;
                end
            end
            // Hand out the results one by one
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.bi_inc   = 1'b1;
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/timer_deadline_queue_core.sv @@
// Timer deadline queue: top level joining the controller and the datapath.
//
// Holds SLOT_COUNT timer slots. Add requests take the lowest free slot, stop
// requests mark a slot stopped, tick requests fire every expired slot,
// earliest deadline first (lower slot on a tie), at most 16 per tick; each
// request answers with one or more results, the final one flagged last, and
// all of them carry the earliest deadline still pending afterwards. The slot
// table sits behind one read and one write port and is walked one slot per
// cycle. A stop reads the target slot and then writes it; an add scans until
// it finds a free slot or reaches the last one; a tick scans the whole table
// for expired slots, then re-arms or frees each fired slot in turn. Every
// request then scans the whole table for the earliest pending deadline and
// presents its results one by one, each waiting while the output register is
// still held by a low i_ready.
// The next request is taken once the last result of the current one has been
// placed in the output register; that register may still be waiting to be
// taken at that point.
module timer_deadline_queue_core #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [tdq_pkg::CMD_W-1:0]       i_command,
    input  logic [tdq_pkg::TIME_W-1:0]      i_current_time,
    input  logic [tdq_pkg::MS_W-1:0]        i_offset_ms,
    input  logic [tdq_pkg::MS_W-1:0]        i_period_ms,
    input  logic [tdq_pkg::HANDLE_W-1:0]    i_target_handle,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [tdq_pkg::KIND_W-1:0]      o_kind,
    output logic [tdq_pkg::HANDLE_W-1:0]    o_handle,
    output logic [tdq_pkg::TIME_W-1:0]      o_next_deadline,
    output logic                            o_next_valid,
    output logic                            o_last
);
    import tdq_pkg::*;

    t_ctl ctl;
    t_sts sts;

    tdq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_sts     (sts),
        .o_ready   (o_ready),
        .o_ctl     (ctl)
    );

    tdq_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_command       (i_command),
        .i_current_time  (i_current_time),
        .i_offset_ms     (i_offset_ms),
        .i_period_ms     (i_period_ms),
        .i_target_handle (i_target_handle),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_handle        (o_handle),
        .o_next_deadline (o_next_deadline),
        .o_next_valid    (o_next_valid),
        .o_last          (o_last)
    );

endmodule

@@ tb/timer_deadline_queue_core_tb.sv @@
// Self-checking testbench for the timer deadline queue core.
`timescale 1ns / 1ps

module timer_deadline_queue_core_tb;
    import tdq_pkg::*;

    localparam int SLOTS    = 16;
    localparam int DRAIN_CY = 2 * SLOTS + 40;

    // One expected or observed result
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   next_deadline;
        logic                next_valid;
        logic                last;
    } t_result;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_valid         = 1'b0;
    logic                o_ready;
    logic [CMD_W-1:0]    i_command       = CMD_TICK;
    logic [TIME_W-1:0]   i_current_time  = '0;
    logic [MS_W-1:0]     i_offset_ms     = '0;
    logic [MS_W-1:0]     i_period_ms     = '0;
    logic [HANDLE_W-1:0] i_target_handle = '0;
    logic                o_valid;
    logic                i_ready         = 1'b0;
    logic [KIND_W-1:0]   o_kind;
    logic [HANDLE_W-1:0] o_handle;
    logic [TIME_W-1:0]   o_next_deadline;
    logic                o_next_valid;
    logic                o_last;

    // Shadow copy of the slot table
    bit                slot_in_use [SLOTS];
    logic [TIME_W-1:0] slot_due    [SLOTS];
    logic [MS_W-1:0]   slot_rearm  [SLOTS];
    bit                slot_repeats[SLOTS];
    bit                slot_halted [SLOTS];

    t_result           awaited_results[$];
    t_result           seen;
    t_result           want;

    int                mismatch_count = 0;
    int                n_requests     = 0;
    int                n_results      = 0;
    int                n_firings      = 0;
    int                n_rejects      = 0;

    // Traffic shaping
    bit                sender_gaps_on = 1'b0;
    bit                sink_stalls_on = 1'b0;
    int                burst_left     = 0;
    logic [TIME_W-1:0] clock_ms       = '0;
    logic [31:0]       stall_pattern  = '1;
    logic [4:0]        stall_phase    = '0;

    timer_deadline_queue_core #(
        .SLOT_COUNT (SLOTS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_current_time  (i_current_time),
        .i_offset_ms     (i_offset_ms),
        .i_period_ms     (i_period_ms),
        .i_target_handle (i_target_handle),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_handle        (o_handle),
        .o_next_deadline (o_next_deadline),
        .o_next_valid    (o_next_valid),
        .o_last          (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Work out the results one request causes and queue them
    function automatic void predict_timer_results(input logic [CMD_W-1:0] cmd,
            input logic [TIME_W-1:0] now, input logic [MS_W-1:0] offset,
            input logic [MS_W-1:0] period, input logic [HANDLE_W-1:0] target);
        t_result           batch[$];
        t_result           r;
        bit                fired_now[SLOTS];
        int                free_slot;
        int                pick;
        bit                any;
        logic [TIME_W-1:0] earliest;
        r = '0;
        foreach (fired_now[i]) fired_now[i] = 1'b0;
        if (cmd == CMD_ADD_ONESHOT || cmd == CMD_ADD_PERIODIC) begin
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!slot_in_use[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot < 0) begin
                r.kind = KIND_FULL;
                r.handle = '0;
                n_rejects++;
            end else begin
                slot_in_use[free_slot]  = 1'b1;
                slot_due[free_slot]     = now + {8'd0, offset};
                slot_repeats[free_slot] = (cmd == CMD_ADD_PERIODIC);
                slot_rearm[free_slot]   = (cmd == CMD_ADD_PERIODIC) ? period : '0;
                slot_halted[free_slot]  = 1'b0;
                r.kind = KIND_ADDED;
                r.handle = HANDLE_W'(free_slot);
            end
            batch.push_back(r);
        end else if (cmd == CMD_STOP) begin
            if (int'(target) < SLOTS && slot_in_use[target]) slot_halted[target] = 1'b1;
            r.kind = KIND_STOPPED;
            r.handle = target;
            batch.push_back(r);
        end else begin
            // Earliest expired first, lower slot on a tie, each slot once
            while (batch.size() < MAX_FIRE) begin
                pick = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_in_use[i] && !fired_now[i] && slot_due[i] <= now &&
                            (pick < 0 || slot_due[i] < slot_due[pick])) pick = i;
                end
                if (pick < 0) break;
                fired_now[pick] = 1'b1;
                if (slot_repeats[pick] && !slot_halted[pick])
                    slot_due[pick] = now + {8'd0, slot_rearm[pick]};
                else
                    slot_in_use[pick] = 1'b0;
                r.kind = KIND_FIRED;
                r.handle = HANDLE_W'(pick);
                batch.push_back(r);
                n_firings++;
            end
            if (batch.size() == 0) begin
                r.kind = KIND_NONE;
                r.handle = '0;
                batch.push_back(r);
            end
        end
        // Earliest deadline left pending, shared by every result
        any = 1'b0;
        earliest = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_in_use[i] && (!any || slot_due[i] < earliest)) begin
                earliest = slot_due[i];
                any = 1'b1;
            end
        end
        foreach (batch[k]) begin
            batch[k].next_deadline = any ? earliest : '0;
            batch[k].next_valid    = any;
            batch[k].last          = (k == batch.size() - 1);
            awaited_results.push_back(batch[k]);
        end
    endfunction

    // Send one request, with burst gaps when enabled
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
            input logic [MS_W-1:0] offset, input logic [MS_W-1:0] period,
            input logic [HANDLE_W-1:0] target);
        int gap;
        if (sender_gaps_on && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 90);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 6);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_current_time  <= now;
        i_offset_ms     <= offset;
        i_period_ms     <= period;
        i_target_handle <= target;
        do @(posedge i_clk); while (!o_ready);
        predict_timer_results(cmd, now, offset, period, target);
        n_requests++;
    endtask

    // Receiver: ready follows the bits of a 32-bit pattern in turn, refreshed each lap
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 5'd1;
        if (stall_phase == 5'd31) begin
            case ($urandom_range(0, 5))
                0:       stall_pattern <= '0;
                1:       stall_pattern <= '1;
                default: stall_pattern <= $urandom;
            endcase
        end
        i_ready <= sink_stalls_on ? stall_pattern[stall_phase] : 1'b1;
    end

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen = '{o_kind, o_handle, o_next_deadline, o_next_valid, o_last};
            n_results++;
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result kind=%0d handle=%0d next=%h/%b last=%b",
                         $time, o_kind, o_handle, o_next_deadline, o_next_valid, o_last);
            end else begin
                want = awaited_results.pop_front();
                if (seen !== want) begin
                    mismatch_count++;
                    $display("%0t: mismatch expected kind=%0d handle=%0d next=%h/%b last=%b",
                             $time, want.kind, want.handle, want.next_deadline,
                             want.next_valid, want.last);
                    $display("%0t:          actual   kind=%0d handle=%0d next=%h/%b last=%b",
                             $time, seen.kind, seen.handle, seen.next_deadline,
                             seen.next_valid, seen.last);
                end
            end
        end
    end

    // Empty table tick
    task automatic test_empty_tick();
        send_request(CMD_TICK, '0, '0, 24'd1, '0);
    endtask

    // Add at zero, stop of a free slot, stop of a live one-shot
    task automatic test_add_and_stop_edges();
        send_request(CMD_ADD_ONESHOT, '0, '0, 24'd1, '0);
        send_request(CMD_STOP, 32'd7, '0, 24'd1, 4'd15);
        send_request(CMD_STOP, 32'd7, '0, 24'd1, 4'd0);
    endtask

    // Fill every slot, then one add too many; include a wrapping deadline
    task automatic test_fill_table();
        send_request(CMD_ADD_PERIODIC, '1, '1, '1, 4'd9);
        for (int i = 2; i < SLOTS; i++) begin
            send_request((i % 2) ? CMD_ADD_PERIODIC : CMD_ADD_ONESHOT, 32'd1000,
                         MS_W'((i % 4) * 10), MS_W'(i * 3), '0);
        end
        send_request(CMD_ADD_ONESHOT, 32'd2000, 24'd5, 24'd5, '0);
    endtask

    // Stop a periodic slot twice
    task automatic test_stop_periodic();
        send_request(CMD_STOP, 32'd1000, '0, 24'd1, 4'd3);
        send_request(CMD_STOP, 32'd1000, '0, 24'd1, 4'd3);
    endtask

    // Expiry order with ties, mass expiry at top of time, wrapped re-arm
    task automatic test_tick_expiry();
        send_request(CMD_TICK, 32'd500, '0, 24'd1, '0);
        send_request(CMD_TICK, 32'd1020, '0, 24'd1, '0);
        send_request(CMD_TICK, '1, '0, 24'd1, '0);
        send_request(CMD_TICK, '1, '0, 24'd1, '0);
        send_request(CMD_ADD_ONESHOT, 32'h8000_0000, 24'h80_0000, 24'h7F_FFFF, '0);
    endtask

    // Mostly well-formed traffic around a moving clock, with some noise
    task automatic test_random_traffic(input int n_items, input bit gaps, input bit stalls,
            input logic [TIME_W-1:0] time_base);
        int                pct;
        int                used[$];
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] now;
        logic [MS_W-1:0]   offset;
        logic [MS_W-1:0]   period;
        logic [HANDLE_W-1:0] target;
        sender_gaps_on = gaps;
        sink_stalls_on = stalls;
        clock_ms = time_base;
        for (int n = 0; n < n_items; n++) begin
            pct = $urandom_range(0, 99);
            cmd = (pct < 30) ? CMD_ADD_ONESHOT : (pct < 50) ? CMD_ADD_PERIODIC :
                  (pct < 63) ? CMD_STOP : CMD_TICK;
            if (cmd == CMD_TICK) clock_ms = clock_ms + $urandom_range(0, 60);
            now = ($urandom_range(0, 9) == 0) ? $urandom : clock_ms;
            offset = ($urandom_range(0, 9) == 0) ? MS_W'($urandom) : MS_W'($urandom_range(0, 150));
            period = ($urandom_range(0, 9) == 0) ? MS_W'($urandom_range(1, 24'hFF_FFFF)) :
                     MS_W'($urandom_range(1, 100));
            target = HANDLE_W'($urandom);
            if (cmd == CMD_STOP && $urandom_range(0, 4) != 0) begin
                used.delete();
                for (int i = 0; i < SLOTS; i++) if (slot_in_use[i]) used.push_back(i);
                if (used.size() > 0) target = HANDLE_W'(used[$urandom_range(0, used.size() - 1)]);
            end
            send_request(cmd, now, offset, period, target);
        end
    endtask

    // Stimulus and final verdict
    initial begin
        foreach (slot_in_use[i]) begin
            slot_in_use[i]  = 1'b0;
            slot_due[i]     = '0;
            slot_rearm[i]   = '0;
            slot_repeats[i] = 1'b0;
            slot_halted[i]  = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_tick();
        test_add_and_stop_edges();
        test_fill_table();
        test_stop_periodic();
        test_tick_expiry();
        test_random_traffic(111, 1'b0, 1'b0, 32'd0);
        test_random_traffic(111, 1'b1, 1'b0, 32'd50_000);
        test_random_traffic(111, 1'b0, 1'b1, 32'h7FFF_F000);
        test_random_traffic(111, 1'b1, 1'b1, 32'hFFFF_F800);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CY) @(posedge i_clk);

        $display("Ran %0d requests over the slot table; %0d results checked.",
                 n_requests, n_results);
        $display("Seen %0d timer firings and %0d rejected adds; %0d mismatches.",
                 n_firings, n_rejects, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("Timed out with %0d results outstanding.", awaited_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
